// ----- rtl/clex_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clex_pkg : shared types and tables of the C subset lexer
// Beat types of both channels, token records, queue entry, keyword tables.
// ----------------------------------------------------------------------------
package clex_pkg;

   localparam int LENGTH_BITS    = 16;
   // depth must be a power of two: the pointers wrap naturally
   localparam int QUEUE_DEPTH    = 4;
   localparam int QUEUE_PTR_BITS = $clog2(QUEUE_DEPTH);
   localparam int KW_COUNT       = 6;
   localparam int KW_MAX_LEN     = 6;

   localparam logic [7:0] CH_SQUOTE = 8'h27;
   localparam logic [7:0] CH_DQUOTE = 8'h22;

   typedef logic [LENGTH_BITS-1:0] len_type;

   typedef enum logic [2:0] {
      LM_IDLE,
      LM_WORD,
      LM_NUM,
      LM_CHR1,
      LM_CHR2,
      LM_STR
   } lex_mode_type;

   typedef enum logic [2:0] {
      TC_KEYWORD,
      TC_IDENT,
      TC_CONST,
      TC_OPER,
      TC_CHAR,
      TC_STRING,
      TC_PUNCT,
      TC_UNTERM
   } tok_class_type;

   typedef struct packed {
      logic [7:0] text_byte;
      logic       is_last;
   } req_type;

   typedef struct packed {
      logic [2:0]  token_class;
      logic [15:0] token_length;
      logic [2:0]  keyword_number;
      logic [7:0]  token_byte;
      logic        last_of_run;
   } rsp_type;

   typedef struct packed {
      tok_class_type cls;
      len_type       len;
      logic [2:0]    kw;
      logic [7:0]    tbyte;
   } tok_type;

   typedef struct packed {
      logic    pair;
      tok_type tok0;
      tok_type tok1;
   } qent_type;

   typedef struct packed {
      logic full;
      logic empty;
   } qstat_type;

   // int, char, return, void, float, struct
   localparam logic [7:0] KW_TEXT [KW_COUNT][KW_MAX_LEN] = '{
      '{"i", "n", "t", 8'h00, 8'h00, 8'h00},
      '{"c", "h", "a", "r", 8'h00, 8'h00},
      '{"r", "e", "t", "u", "r", "n"},
      '{"v", "o", "i", "d", 8'h00, 8'h00},
      '{"f", "l", "o", "a", "t", 8'h00},
      '{"s", "t", "r", "u", "c", "t"}
   };

   localparam logic [2:0] KW_LEN [KW_COUNT] = '{3'd3, 3'd4, 3'd6, 3'd4, 3'd5, 3'd6};

   function automatic logic is_op(input logic [7:0] b);
      logic r;
      unique case (b) inside
         "+", "-", "*", "/", "=", ";", "{", "}", "(", ")": r = 1'b1;
         default: r = 1'b0;
      endcase
      return r;
   endfunction

endpackage

// ----- rtl/clex_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clex_front : byte classifier and lexer state machine
// One byte a beat unless the queue is full; pushes zero, one or two closed tokens.
// ----------------------------------------------------------------------------
module clex_front (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  clex_pkg::req_type  req_data,
   input  clex_pkg::qstat_type q_stat,
   output logic               push,
   output clex_pkg::qent_type push_data
);
   import clex_pkg::*;

   lex_mode_type mode_ff, mode_in, step_mode, start_mode;
   len_type      len_ff, len_in, step_len, len_inc;
   logic [5:0]   cand_ff, cand_in, step_cand, start_cand, keep;

   logic [7:0] b;
   logic       last, accept;
   logic       c_alpha, c_digit, c_space, c_sq, c_dq, c_alnum;
   logic       start_emit;
   tok_type    start_tok, ta, tc;
   logic       va, vb, vc;

   function automatic tok_type mk_tok(input tok_class_type cls, input len_type len);
      tok_type t;
      t.cls   = cls;
      t.len   = len;
      t.kw    = '0;
      t.tbyte = '0;
      return t;
   endfunction

   function automatic tok_type word_tok(input logic [5:0] cand, input len_type len);
      tok_type t;
      logic    hit;
      t   = mk_tok(TC_IDENT, len);
      hit = 1'b0;
      for (int k = 0; k < KW_COUNT; k++) begin
         if (!hit && cand[k] && len == LENGTH_BITS'(KW_LEN[k])) begin
            t.cls = TC_KEYWORD;
            t.kw  = 3'(k);
            hit   = 1'b1;
         end
      end
      return t;
   endfunction

   assign b         = req_data.text_byte;
   assign last      = req_data.is_last;
   assign req_ready = !q_stat.full;
   assign accept    = req_valid && req_ready;

   assign c_alpha = (b >= "a" && b <= "z") || (b >= "A" && b <= "Z");
   assign c_digit = b >= "0" && b <= "9";
   assign c_space = b == 8'h20 || (b >= 8'h09 && b <= 8'h0D);
   assign c_sq    = b == CH_SQUOTE;
   assign c_dq    = b == CH_DQUOTE;
   assign c_alnum = c_alpha || c_digit;

   assign len_inc = (len_ff == '1) ? len_ff : len_ff + len_type'(1);

   always_comb begin
      for (int k = 0; k < KW_COUNT; k++) begin
         keep[k] = cand_ff[k] && (len_ff < len_type'(KW_MAX_LEN)) &&
                   (len_ff[2:0] < KW_LEN[k]) && (KW_TEXT[k][len_ff[2:0]] == b);
         start_cand[k] = KW_TEXT[k][0] == b;
      end
   end

   always_comb begin
      start_emit = 1'b0;
      if (c_space) begin
         start_mode = LM_IDLE;
      end else if (c_alpha) begin
         start_mode = LM_WORD;
      end else if (c_digit) begin
         start_mode = LM_NUM;
      end else if (c_sq) begin
         start_mode = LM_CHR1;
      end else if (c_dq) begin
         start_mode = LM_STR;
      end else begin
         start_mode = LM_IDLE;
         start_emit = 1'b1;
      end
      start_tok       = mk_tok(is_op(b) ? TC_OPER : TC_PUNCT, len_type'(1));
      start_tok.tbyte = b;
   end

   // next state
   always_comb begin
      step_mode = mode_ff;
      step_len  = len_ff;
      step_cand = cand_ff;
      unique case (mode_ff)
         LM_WORD: begin
            if (c_alnum) begin
               step_len  = len_inc;
               step_cand = keep;
            end else begin
               step_mode = start_mode;
               step_len  = len_type'(1);
               step_cand = start_cand;
            end
         end
         LM_NUM: begin
            if (c_digit) begin
               step_len = len_inc;
            end else begin
               step_mode = start_mode;
               step_len  = len_type'(1);
               step_cand = start_cand;
            end
         end
         LM_CHR1: begin
            step_mode = LM_CHR2;
            step_len  = len_type'(2);
         end
         LM_CHR2: begin
            step_mode = LM_IDLE;
         end
         LM_STR: begin
            step_len = len_inc;
            if (c_dq) begin
               step_mode = LM_IDLE;
            end
         end
         LM_IDLE: begin
            step_mode = start_mode;
            step_len  = len_type'(1);
            step_cand = start_cand;
         end
         default: begin
            step_mode = LM_IDLE;
         end
      endcase
      mode_in = mode_ff;
      len_in  = len_ff;
      cand_in = cand_ff;
      if (accept) begin
         mode_in = last ? LM_IDLE : step_mode;
         len_in  = step_len;
         cand_in = step_cand;
      end
   end

   // tokens closed by this byte: ended token, single-byte token, end-of-text flush
   always_comb begin
      va = 1'b0;
      vb = 1'b0;
      vc = 1'b0;
      ta = mk_tok(TC_IDENT, len_ff);
      tc = mk_tok(TC_UNTERM, step_len);
      unique case (mode_ff)
         LM_WORD: begin
            if (!c_alnum) begin
               va = 1'b1;
               ta = word_tok(cand_ff, len_ff);
               vb = start_emit;
            end
         end
         LM_NUM: begin
            if (!c_digit) begin
               va = 1'b1;
               ta = mk_tok(TC_CONST, len_ff);
               vb = start_emit;
            end
         end
         LM_CHR2: begin
            va = 1'b1;
            ta = mk_tok(TC_CHAR, len_type'(3));
         end
         LM_STR: begin
            if (c_dq) begin
               va = 1'b1;
               ta = mk_tok(TC_STRING, len_inc);
            end
         end
         LM_IDLE: begin
            vb = start_emit;
         end
         default: begin
            va = 1'b0;
         end
      endcase
      if (last) begin
         unique case (step_mode) inside
            LM_WORD: begin
               vc = 1'b1;
               tc = word_tok(step_cand, step_len);
            end
            LM_NUM: begin
               vc = 1'b1;
               tc = mk_tok(TC_CONST, step_len);
            end
            LM_CHR1, LM_CHR2, LM_STR: begin
               vc = 1'b1;
            end
            default: begin
               vc = 1'b0;
            end
         endcase
      end
   end

   assign push           = accept && (va || vb || vc);
   assign push_data.pair = (va && vb) || (va && vc) || (vb && vc);
   assign push_data.tok0 = va ? ta : (vb ? start_tok : tc);
   assign push_data.tok1 = (va && vb) ? start_tok : tc;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= LM_IDLE;
         len_ff  <= '0;
         cand_ff <= '0;
      end else begin
         mode_ff <= mode_in;
         len_ff  <= len_in;
         cand_ff <= cand_in;
      end
   end

   a_last_idles: assert property (@(posedge clock) disable iff (reset)
      accept && last |=> mode_ff == LM_IDLE)
      else $error("lexer not idle after final byte");

endmodule

// ----- rtl/clex_queue.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clex_queue : token queue between front and back
// Small register FIFO of token-pair entries.
// ----------------------------------------------------------------------------
module clex_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  clex_pkg::qent_type  push_data,
   input  logic                pop,
   output clex_pkg::qent_type  head,
   output clex_pkg::qstat_type q_stat
);
   import clex_pkg::*;

   qent_type                  mem_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_BITS-1:0] wr_ff, wr_in, rd_ff, rd_in;
   logic [QUEUE_PTR_BITS:0]   cnt_ff, cnt_in;

   assign head         = mem_ff[rd_ff];
   assign q_stat.full  = cnt_ff == (QUEUE_PTR_BITS+1)'(QUEUE_DEPTH);
   assign q_stat.empty = cnt_ff == '0;

   always_comb begin
      wr_in  = push ? wr_ff + 1'b1 : wr_ff;
      rd_in  = pop ? rd_ff + 1'b1 : rd_ff;
      case ({push, pop})
         2'b10:   cnt_in = cnt_ff + 1'b1;
         2'b01:   cnt_in = cnt_ff - 1'b1;
         default: cnt_in = cnt_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= (QUEUE_PTR_BITS+1)'(QUEUE_DEPTH))
      else $error("queue count beyond depth");

   a_cnt_ptrs: assert property (@(posedge clock) disable iff (reset)
      cnt_ff[QUEUE_PTR_BITS-1:0] == QUEUE_PTR_BITS'(wr_ff - rd_ff))
      else $error("queue count and pointers disagree");

endmodule

// ----- rtl/clex_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clex_back : token serialiser and result register
// Emits the tokens of each queue entry one beat at a time.
// ----------------------------------------------------------------------------
module clex_back (
   input  logic                clock,
   input  logic                reset,
   input  clex_pkg::qent_type  head,
   input  clex_pkg::qstat_type q_stat,
   output logic                pop,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output clex_pkg::rsp_type   rsp_data
);
   import clex_pkg::*;

   logic    sel_ff, sel_in;
   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_ff, rsp_in;
   logic    load, is_end;
   tok_type tok;

   function automatic logic [15:0] sat16(input len_type len);
      logic [31:0] w;
      w = 32'(len);
      return (|w[31:16]) ? 16'hFFFF : w[15:0];
   endfunction

   assign load   = !q_stat.empty && (!rsp_valid_ff || rsp_ready);
   assign tok    = sel_ff ? head.tok1 : head.tok0;
   assign is_end = sel_ff || !head.pair;
   assign pop    = load && is_end;

   always_comb begin
      sel_in       = load ? !is_end : sel_ff;
      rsp_valid_in = load || (rsp_valid_ff && !rsp_ready);
      rsp_in       = rsp_ff;
      if (load) begin
         rsp_in.token_class    = tok.cls;
         rsp_in.token_length   = sat16(tok.len);
         rsp_in.keyword_number = tok.kw;
         rsp_in.token_byte     = tok.tbyte;
         rsp_in.last_of_run    = is_end;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
      if (reset) begin
         sel_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         sel_ff       <= sel_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   a_sel_pair: assert property (@(posedge clock) disable iff (reset)
      sel_ff |-> !q_stat.empty && head.pair)
      else $error("second token selected without a pair entry");

endmodule

// ----- rtl/c_subset_lexer.sv -----
`timescale 1ns / 1ps
// A closed token is written into a queue entry, then loaded into the output register.
// One byte per cycle while the queue has room; one result beat per cycle while rsp_ready holds.
// A byte that closes two tokens takes two output beats; the 4-entry queue absorbs it.
// Reset: synchronous, clears lexer state, queue pointers and output valid.
// ----------------------------------------------------------------------------
// c_subset_lexer : streaming lexer for a small C subset
// Front classifies bytes and closes tokens, back serialises token records.
// ----------------------------------------------------------------------------
module c_subset_lexer (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  clex_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output clex_pkg::rsp_type rsp_data
);
   import clex_pkg::*;

   logic      push, pop;
   qent_type  push_data, head;
   qstat_type q_stat;

   clex_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .q_stat    (q_stat),
      .push      (push),
      .push_data (push_data)
   );

   clex_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (pop),
      .head      (head),
      .q_stat    (q_stat)
   );

   clex_back u_back (
      .clock     (clock),
      .reset     (reset),
      .head      (head),
      .q_stat    (q_stat),
      .pop       (pop),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule
